### design/line_sensor_baseline_detector_assert.svh
// Assertion macros shared by the checker.
`ifndef LINE_SENSOR_BASELINE_DETECTOR_ASSERT_SVH
`define LINE_SENSOR_BASELINE_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define LSBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lsbd_pkg.sv
`timescale 1ns / 1ps

package lsbd_pkg;

    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 24;
    localparam int SCAN_W    = 8;
    localparam int SIDE_W    = 2;
    localparam int OP_W      = 2;
    localparam int ANGLE_W   = 9;
    localparam int NUM_SIDES = 3;
    localparam int LANE_PORTS = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DETECT = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_FRONT = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORED = 2'd2;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LEFT  = 9'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_RIGHT = -9'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_FRONT = 9'sd180;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NONE  = -9'sd1;

    typedef struct packed {
        logic              load;    // store margin
        logic              accum;   // add reading into sum
        logic              fresh;   // drop old sum before adding
        logic              start;   // last scan: move sum into divider
        logic              step;    // one divider iteration
        logic              commit;  // write quotient as baseline
        logic [SIDE_W-1:0] side;
        logic [SCAN_W-1:0] divisor;
    } t_lane_ctl;

endpackage

### design/line_sensor_baseline_detector.sv
// A detect result is registered in the cycle after its item is accepted.
// A baseline scan that ends an attempt gives its result once the dividers finish and S_FIN commits.
// Load, detect and non-final scans stall the input only while a waiting result is not
// drained; a final scan holds it stalled while the 24-step lane dividers run and commit.
// Reset (synchronous, active low) clears tables, sums, counters and output valid, and loads config defaults.
`timescale 1ns / 1ps

module line_sensor_baseline_detector #(
    parameter int CHANNELS     = 8,
    parameter int MAX_ATTEMPTS = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [lsbd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lsbd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [lsbd_pkg::OP_W-1:0]              i_opcode,
    input  logic [lsbd_pkg::SIDE_W-1:0]            i_side,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_0,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_1,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_2,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_3,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_4,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_5,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_6,
    input  logic [lsbd_pkg::VALUE_W-1:0]           i_lane_value_7,
    // output channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_result_kind,
    output logic [lsbd_pkg::SIDE_W-1:0]            o_side_out,
    output logic                                   o_line_found,
    output logic signed [lsbd_pkg::ANGLE_W-1:0]    o_escape_angle,
    output logic                                   o_retry_started,
    output logic                                   o_capture_complete,
    output logic                                   o_zero_warning
);

    localparam logic [2:0] MAX_ATT = 3'(MAX_ATTEMPTS);

    // one-hot sequencer: idle, lane dividers running, result waiting to load
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                              r_state;
    logic [lsbd_pkg::CNT_W-1:0]          r_div_cnt;

    // configuration registers
    logic [lsbd_pkg::NUM_SIDES-1:0]      r_side_en;
    logic [lsbd_pkg::SCAN_W-1:0]         r_sample_count;
    logic [lsbd_pkg::VALUE_W-1:0]        r_ignored;

    // capture bookkeeping
    logic [lsbd_pkg::SCAN_W-1:0]         r_scans;
    logic [1:0]                          r_attempt;
    logic [lsbd_pkg::SIDE_W-1:0]         r_cap_side;

    // output register
    logic                                r_out_valid;
    logic                                r_out_kind;
    logic [lsbd_pkg::SIDE_W-1:0]         r_out_side;
    logic                                r_out_line;
    logic signed [lsbd_pkg::ANGLE_W-1:0] r_out_angle;
    logic                                r_out_retry;
    logic                                r_out_complete;
    logic                                r_out_warn;

    logic [lsbd_pkg::VALUE_W-1:0]        w_vals [lsbd_pkg::LANE_PORTS];
    logic [lsbd_pkg::SIDE_W-1:0]         w_side_n;
    logic                                w_accept;
    logic                                w_is_load;
    logic                                w_is_detect;
    logic                                w_sample_ok;
    logic                                w_fresh;
    logic [lsbd_pkg::SCAN_W-1:0]         w_scans_next;
    logic                                w_last;
    logic                                w_commit;
    logic                                w_retry;
    logic [CHANNELS-1:0]                 w_over;
    logic [CHANNELS-1:0]                 w_zero;
    logic                                w_line;
    logic                                w_needs;
    logic signed [lsbd_pkg::ANGLE_W-1:0] w_angle;
    lsbd_pkg::t_lane_ctl                 w_ctl;

    assign w_vals[0] = i_lane_value_0;
    assign w_vals[1] = i_lane_value_1;
    assign w_vals[2] = i_lane_value_2;
    assign w_vals[3] = i_lane_value_3;
    assign w_vals[4] = i_lane_value_4;
    assign w_vals[5] = i_lane_value_5;
    assign w_vals[6] = i_lane_value_6;
    assign w_vals[7] = i_lane_value_7;

    // side code three behaves as front
    assign w_side_n = (i_side == lsbd_pkg::SIDE_SPARE) ? lsbd_pkg::SIDE_FRONT : i_side;

    // hold input off while dividing or committing, or while a waiting result is not drained
    assign o_stall  = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    assign w_is_load   = w_accept && (i_opcode == lsbd_pkg::OP_LOAD);
    assign w_is_detect = w_accept && (i_opcode == lsbd_pkg::OP_DETECT);
    assign w_sample_ok = w_accept && (i_opcode == lsbd_pkg::OP_SAMPLE)
                      && r_side_en[w_side_n] && (r_sample_count != '0);

    // a scan for another side throws away a capture in progress
    assign w_fresh      = (r_scans != '0) && (r_cap_side != w_side_n);
    assign w_scans_next = (w_fresh ? '0 : r_scans) + 8'd1;
    assign w_last       = w_scans_next >= r_sample_count;

    assign w_commit = (r_state == S_FIN) && (!r_out_valid || !i_stall);
    assign w_retry  = w_needs && (({1'b0, r_attempt} + 3'd1) < MAX_ATT);

    always_comb begin
        w_ctl.load    = w_is_load;
        w_ctl.accum   = w_sample_ok;
        w_ctl.fresh   = w_fresh;
        w_ctl.start   = w_sample_ok && w_last;
        w_ctl.step    = (r_state == S_DIV);
        w_ctl.commit  = w_commit;
        w_ctl.side    = (r_state == S_FIN) ? r_cap_side : w_side_n;
        w_ctl.divisor = r_scans;
    end

    // one lane per sensor channel
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        lsbd_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_value       (w_vals[c]),
            .i_ignored     (r_ignored),
            .o_over        (w_over[c]),
            .o_zero_active (w_zero[c])
        );
    end

    lsbd_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_over    (w_over),
        .i_zero    (w_zero),
        .i_enabled (r_side_en[w_ctl.side]),
        .i_side    (w_ctl.side),
        .o_line    (w_line),
        .o_needs   (w_needs),
        .o_angle   (w_angle)
    );

    // config, sequencer and capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_en      <= 3'd7;
            r_sample_count <= 8'd8;
            r_ignored      <= 16'hFFFF;
            r_state        <= S_IDLE;
            r_div_cnt      <= '0;
            r_scans        <= '0;
            r_attempt      <= '0;
            r_cap_side     <= lsbd_pkg::SIDE_LEFT;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lsbd_pkg::CFG_SIDE_EN: r_side_en      <= i_cfg_data[lsbd_pkg::NUM_SIDES-1:0];
                    lsbd_pkg::CFG_SAMPLES: r_sample_count <= i_cfg_data[lsbd_pkg::SCAN_W-1:0];
                    lsbd_pkg::CFG_IGNORED: r_ignored      <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_ctl.start) begin
                        r_state   <= S_DIV;
                        r_div_cnt <= '0;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == lsbd_pkg::DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_sample_ok) begin
                r_scans    <= w_scans_next;
                r_cap_side <= w_side_n;
                if (w_fresh) begin
                    r_attempt <= '0;
                end
            end else if (w_commit) begin
                r_scans   <= '0;
                r_attempt <= w_retry ? r_attempt + 2'd1 : 2'd0;
            end

            if (w_is_detect || w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_is_detect) begin
            r_out_kind     <= 1'b0;
            r_out_side     <= w_side_n;
            r_out_line     <= w_line;
            r_out_angle    <= w_angle;
            r_out_retry    <= 1'b0;
            r_out_complete <= 1'b0;
            r_out_warn     <= 1'b0;
        end else if (w_commit) begin
            r_out_kind     <= 1'b1;
            r_out_side     <= r_cap_side;
            r_out_line     <= 1'b0;
            r_out_angle    <= '0;
            r_out_retry    <= w_retry;
            r_out_complete <= !w_retry;
            r_out_warn     <= !w_retry && w_needs;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_out_kind;
    assign o_side_out         = r_out_side;
    assign o_line_found       = r_out_line;
    assign o_escape_angle     = r_out_angle;
    assign o_retry_started    = r_out_retry;
    assign o_capture_complete = r_out_complete;
    assign o_zero_warning     = r_out_warn;

endmodule

### design/lsbd_lane.sv
`timescale 1ns / 1ps

module lsbd_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lsbd_pkg::t_lane_ctl                i_ctl,
    input  logic [lsbd_pkg::VALUE_W-1:0]       i_value,
    input  logic [lsbd_pkg::VALUE_W-1:0]       i_ignored,
    output logic                               o_over,
    output logic                               o_zero_active
);

    logic [lsbd_pkg::VALUE_W-1:0] r_margin [lsbd_pkg::NUM_SIDES];
    logic [lsbd_pkg::VALUE_W-1:0] r_base   [lsbd_pkg::NUM_SIDES];
    logic [lsbd_pkg::SUM_W-1:0]   r_sum;
    logic [lsbd_pkg::SUM_W-1:0]   r_quo;
    logic [lsbd_pkg::SCAN_W-1:0]  r_rem;

    logic [lsbd_pkg::SUM_W-1:0]   n_sum;
    logic [lsbd_pkg::SCAN_W:0]    w_trial;
    logic [lsbd_pkg::SCAN_W:0]    w_diff;
    logic                         w_ge;
    logic [lsbd_pkg::VALUE_W:0]   w_limit;

    assign n_sum   = (i_ctl.fresh ? '0 : r_sum) + lsbd_pkg::SUM_W'(i_value);
    assign w_trial = {r_rem, r_quo[lsbd_pkg::SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_ctl.divisor};
    assign w_diff  = w_trial - {1'b0, i_ctl.divisor};

    // threshold at 17 bits, no wrap
    assign w_limit = {1'b0, r_base[i_ctl.side]} + {1'b0, r_margin[i_ctl.side]};
    assign o_over  = {1'b0, i_value} > w_limit;

    assign o_zero_active = (r_quo[lsbd_pkg::VALUE_W-1:0] == '0)
                        && (r_margin[i_ctl.side] != i_ignored);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < lsbd_pkg::NUM_SIDES; s++) begin
                r_margin[s] <= '0;
                r_base[s]   <= '0;
            end
            r_sum <= '0;
        end else begin
            if (i_ctl.load) begin
                r_margin[i_ctl.side] <= i_value;
            end
            if (i_ctl.accum) begin
                r_sum <= i_ctl.start ? '0 : n_sum;
            end
            if (i_ctl.commit) begin
                r_base[i_ctl.side] <= r_quo[lsbd_pkg::VALUE_W-1:0];
            end
        end
    end

    // restoring divider, quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= n_sum;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? w_diff[lsbd_pkg::SCAN_W-1:0] : w_trial[lsbd_pkg::SCAN_W-1:0];
            r_quo <= {r_quo[lsbd_pkg::SUM_W-2:0], w_ge};
        end
    end

endmodule

### design/lsbd_merge.sv
`timescale 1ns / 1ps

module lsbd_merge #(
    parameter int CHANNELS = 8
) (
    input  logic [CHANNELS-1:0]                    i_over,
    input  logic [CHANNELS-1:0]                    i_zero,
    input  logic                                   i_enabled,
    input  logic [lsbd_pkg::SIDE_W-1:0]            i_side,
    output logic                                   o_line,
    output logic                                   o_needs,
    output logic signed [lsbd_pkg::ANGLE_W-1:0]    o_angle
);

    logic signed [lsbd_pkg::ANGLE_W-1:0] w_side_angle;

    assign o_line  = i_enabled && (|i_over);
    assign o_needs = |i_zero;

    always_comb begin
        unique case (i_side)
            lsbd_pkg::SIDE_LEFT:  w_side_angle = lsbd_pkg::ANGLE_LEFT;
            lsbd_pkg::SIDE_RIGHT: w_side_angle = lsbd_pkg::ANGLE_RIGHT;
            default:              w_side_angle = lsbd_pkg::ANGLE_FRONT;
        endcase
    end

    assign o_angle = o_line ? w_side_angle : lsbd_pkg::ANGLE_NONE;

endmodule

### design/lsbd_checker.sv
`timescale 1ns / 1ps
`include "line_sensor_baseline_detector_assert.svh"

module lsbd_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   o_stall,
    input  logic [lsbd_pkg::OP_W-1:0]              i_opcode,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic                                   o_result_kind,
    input  logic                                   o_line_found,
    input  logic signed [lsbd_pkg::ANGLE_W-1:0]    o_escape_angle,
    input  logic                                   o_retry_started,
    input  logic                                   o_capture_complete,
    input  logic                                   o_zero_warning
);

    `LSBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    `LSBD_ASSERT_NEXT(a_detect_answers, i_clk, i_rst_n, i_valid && !o_stall && (i_opcode == lsbd_pkg::OP_DETECT), o_valid && !o_result_kind, "detect item gave no answer")

    `LSBD_ASSERT_NOW(a_attempt_end, i_clk, i_rst_n, o_valid && o_result_kind, (o_retry_started ^ o_capture_complete) && !o_line_found && !(o_zero_warning && !o_capture_complete), "bad attempt-end flags")

    `LSBD_ASSERT_NOW(a_detect_fields, i_clk, i_rst_n, o_valid && !o_result_kind, !o_retry_started && !o_capture_complete && !o_zero_warning && (o_line_found == (o_escape_angle != lsbd_pkg::ANGLE_NONE)), "bad detect fields")

endmodule

bind line_sensor_baseline_detector lsbd_checker u_lsbd_checker (.*);
